>>> sv/lph_pkg.sv
// shared types, constants and helpers for the linear probing hash set
`default_nettype none
package lph_pkg;

  localparam int SLOTS  = 1024;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = IDX_W + 1;
  localparam int KEY_W  = 31;
  localparam int SIZE_W = 11;
  localparam int STEP_W = $clog2(KEY_W);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CHECK
  } state_t;

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
  } slot_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    slot_t            wdata;
  } mem_req_t;

  // size register to slots in use: zero acts as one, clamp at SLOTS
  function automatic logic [CNT_W-1:0] eff_size(input logic [SIZE_W-1:0] ts);
    logic [CNT_W-1:0] n;
    if (ts == '0) begin
      n = CNT_W'(1);
    end else if (int'(ts) > SLOTS) begin
      n = CNT_W'(SLOTS);
    end else begin
      n = CNT_W'(ts);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

>>> sv/lph_mod.sv
// iterative remainder unit: key modulo slot count, one key bit per cycle
`default_nettype none
module lph_mod (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [lph_pkg::KEY_W-1:0] dividend,
  input  wire logic [lph_pkg::CNT_W-1:0] divisor,
  output logic                           done,
  output logic [lph_pkg::IDX_W-1:0]      rem
);
  import lph_pkg::*;

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [KEY_W-1:0]  key_sh_r, key_sh_nxt;
  logic [CNT_W-1:0]  div_r, div_nxt;
  logic [IDX_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  trial;

  always_comb begin
    run_nxt    = run_r;
    done_nxt   = 1'b0;
    step_nxt   = step_r;
    key_sh_nxt = key_sh_r;
    div_nxt    = div_r;
    rem_nxt    = rem_r;
    // shift in the next key bit, subtract once if the partial reaches the divisor
    trial = {rem_r, key_sh_r[KEY_W-1]};
    if (start) begin
      run_nxt    = 1'b1;
      step_nxt   = '0;
      key_sh_nxt = dividend;
      div_nxt    = divisor;
      rem_nxt    = '0;
    end else if (run_r) begin
      if (trial >= div_r) begin
        rem_nxt = IDX_W'(trial - div_r);
      end else begin
        rem_nxt = IDX_W'(trial);
      end
      key_sh_nxt = {key_sh_r[KEY_W-2:0], 1'b0};
      step_nxt   = step_r + STEP_W'(1);
      if (step_r == STEP_W'(KEY_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    key_sh_r <= key_sh_nxt;
    div_r    <= div_nxt;
    rem_r    <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

>>> sv/lph_mem.sv
// slot memory: used bit and key per slot, one write and one registered read
`default_nettype none
module lph_mem (
  input  wire logic              clk,
  input  wire lph_pkg::mem_req_t req,
  output lph_pkg::slot_t         rdata
);
  import lph_pkg::*;

  slot_t mem [SLOTS];
  slot_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata_r <= mem[req.addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> sv/linear_probe_hash_set.sv
// an accepted start probes between one slot and size slots before out_valid
// the home slot comes from a bit-serial remainder unit; each probe is a
// slot memory read (ST_READ) then a compare (ST_CHECK)
// busy stays high for the whole item, so a new item is taken only once the last is through; out_valid strobes once
// after reset every slot of the slot memory is swept empty with busy high
// cmd 3 answers the cycle after start with found 0, status 0
`default_nettype none
module linear_probe_hash_set (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 in_cmd,
  input  wire logic [lph_pkg::KEY_W-1:0]  in_key,
  output logic                            out_valid,
  output logic                            out_found,
  output logic                            out_status,
  input  wire logic                       cfg_we,
  input  wire logic [lph_pkg::SIZE_W-1:0] cfg_wdata
);
  import lph_pkg::*;

  state_t            state_r, state_nxt;
  logic [SIZE_W-1:0] size_r;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic [IDX_W-1:0]  clr_r, clr_nxt;
  logic [1:0]        cmd_r, cmd_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic              out_status_r, out_status_nxt;

  logic              accept;
  logic              mod_start;
  logic              mod_done;
  logic [IDX_W-1:0]  mod_rem;
  logic [CNT_W-1:0]  idx_inc;
  mem_req_t          mem_req;
  slot_t             rd_slot;

  lph_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (key_r),
    .divisor  (n_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  lph_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rd_slot)
  );

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign idx_inc = {1'b0, idx_r} + CNT_W'(1);

  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    idx_nxt        = idx_r;
    left_nxt       = left_r;
    clr_nxt        = clr_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    out_valid_nxt  = 1'b0;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    mod_start      = 1'b0;
    mem_req.we     = 1'b0;
    mem_req.addr   = idx_r;
    mem_req.wdata  = '{used: 1'b0, key: key_r};

    unique case (state_r)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = clr_r;
        mem_req.wdata = '{used: 1'b0, key: '0};
        clr_nxt       = clr_r + IDX_W'(1);
        if (clr_r == IDX_W'(SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt = in_cmd;
          key_nxt = in_key;
          n_nxt   = eff_size(size_r);
          if (in_cmd == CMD_INSERT || in_cmd == CMD_FIND || in_cmd == CMD_REMOVE) begin
            state_nxt = ST_HASH;
          end else begin
            out_valid_nxt  = 1'b1;
            out_found_nxt  = 1'b0;
            out_status_nxt = 1'b0;
          end
        end
      end
      ST_HASH: begin
        // first hash cycle kicks the remainder unit with the latched key and size
        mod_start = (left_r == '1);
        left_nxt  = n_r - CNT_W'(1);
        if (mod_done) begin
          idx_nxt   = mod_rem;
          state_nxt = ST_READ;
        end else if (left_r == '1) begin
          left_nxt = '0;
        end
      end
      ST_READ: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (!rd_slot.used) begin
          if (cmd_r == CMD_INSERT) begin
            mem_req.we    = 1'b1;
            mem_req.wdata = '{used: 1'b1, key: key_r};
          end
          out_valid_nxt  = 1'b1;
          out_found_nxt  = 1'b0;
          out_status_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end else if (rd_slot.key == key_r) begin
          if (cmd_r == CMD_REMOVE) begin
            mem_req.we    = 1'b1;
            mem_req.wdata = '{used: 1'b0, key: key_r};
          end
          out_valid_nxt  = 1'b1;
          out_found_nxt  = 1'b1;
          out_status_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end else if (left_r == '0) begin
          // walked every slot in use without a hit or a hole
          out_valid_nxt  = 1'b1;
          out_found_nxt  = 1'b0;
          out_status_nxt = (cmd_r == CMD_INSERT);
          state_nxt      = ST_IDLE;
        end else begin
          left_nxt  = left_r - CNT_W'(1);
          idx_nxt   = (idx_inc >= n_r) ? '0 : idx_inc[IDX_W-1:0];
          state_nxt = ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // arm the one-shot remainder start marker on entry to hashing
    if (state_r == ST_IDLE && state_nxt == ST_HASH) begin
      left_nxt = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      size_r      <= SIZE_W'(1024);
      clr_r       <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
    end
    n_r          <= n_nxt;
    idx_r        <= idx_nxt;
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_found  = out_found_r;
  assign out_status = out_status_r;

endmodule
`default_nettype wire
